// ===== hdl/blce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blce_pkg: shared types and constants of the battery level estimator
// Holds the divider request and response bundles and the fixed constants
// of the gauge sample format.
// ----------------------------------------------------------------------------
package blce_pkg;

  // Divider geometry: a 31-bit dividend, a 16-bit divisor, up to 15 quotient bits.
  localparam int NUM_W  = 31;
  localparam int DEN_W  = 16;
  localparam int QUOT_W = 15;

  // Steps of a long run (percentage mapping) and of a short run (rounding).
  localparam logic [3:0] DIV_STEPS_LONG  = 4'd15;
  localparam logic [3:0] DIV_STEPS_SHORT = 4'd7;

  // One hundred percent in Q7.8.
  localparam logic [14:0] PCT_FULL_Q = 15'd25600;

  // Status word bits and the idle time-to-full code.
  localparam int          FLAG_DSG_BIT = 0;
  localparam int          FLAG_FC_BIT  = 9;
  localparam logic [15:0] TTF_IDLE     = 16'hFFFF;

  typedef struct packed {
    logic              start;
    logic              short_run;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hdl/battery_level_charge_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_level_charge_estimator: battery level and charge state from gauge samples
// Maps cell voltage to a smoothed percentage and infers charging and
// discharging from currents, status flags, time-to-full and USB presence.
// ----------------------------------------------------------------------------
// How to use this block:
// Each request on the in_ channel is one gauge sample. It yields exactly one
// request on the out_ channel carrying the rounded level (0 to 100) and the
// charging and discharging flags. The cfg_ port writes the thresholds; write
// it only while no sample is in flight.
// From acceptance to the result being offered, one sample makes two passes
// through the shared bit-serial divider (15 steps for the voltage-to-percent
// mapping, 7 steps for rounding the window average) between the MAP, LOAD,
// WIN and DONE states. When the voltage sits at or beyond either end of the
// range the first pass is skipped. in_tready is high only while the sequencer
// is idle. A finished result sits in the output register; the next sample may
// be accepted meanwhile, and the sequencer waits at its last step only if the
// previous result is still unclaimed. Reset clears the averaging window, the
// boost baseline and streak, drops any pending result and restores the default
// thresholds.
// ----------------------------------------------------------------------------
module battery_level_charge_estimator #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // voltage_mv[15:0], current_ma[31:16], avg_current_ma[47:32],
  // status_flags[63:48], time_to_full_min[79:64], usb_host_present[80], zeros
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // level_pct[6:0], charging[7], discharging[8], zeros
  output logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  // Holds the window sum plus the rounding bias.
  localparam int SUM_W = 16 + $clog2(WINDOW_DEPTH);
  localparam logic [SUM_W-1:0]           LVL_BIAS = SUM_W'(WINDOW_DEPTH * 128);
  localparam logic [blce_pkg::DEN_W-1:0] LVL_DEN  = blce_pkg::DEN_W'(WINDOW_DEPTH * 256);
  localparam logic [IDX_W-1:0]           IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);

  // Register indexes of the configuration port.
  localparam logic [7:0] REG_EMPTY      = 8'd0;
  localparam logic [7:0] REG_FULL       = 8'd1;
  localparam logic [7:0] REG_MAINT      = 8'd2;
  localparam logic [7:0] REG_DIS_MA     = 8'd3;
  localparam logic [7:0] REG_RISE       = 8'd4;
  localparam logic [7:0] REG_RESET_DROP = 8'd5;
  localparam logic [7:0] REG_DROP       = 8'd6;
  localparam logic [7:0] REG_STREAK     = 8'd7;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MAP   = 7'b0000010,
    ST_LOAD1 = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_WIN   = 7'b0010000,
    ST_LOAD2 = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [15:0] empty_mv_r, full_mv_r, maint_mv_r;
  logic [14:0] dis_ma_r;
  logic [15:0] rise_mv_r, reset_drop_r, drop_mv_r;
  logic [7:0]  streak_need_r;

  // Captured sample.
  logic [15:0] s_mv_r;
  logic [15:0] s_cur_r, s_avg_r;
  logic [15:0] s_flags_r, s_ttf_r;
  logic        s_usb_r;

  // Datapath.
  logic [blce_pkg::NUM_W-1:0] prod_r;
  logic [14:0]                raw_r;
  logic                       phase_r;
  logic [6:0]                 level_r;
  logic [SUM_W-1:0]           sum_r;
  logic [14:0]                first_r;
  logic                       primed_r;
  logic [IDX_W-1:0]           idx_r;
  logic [WINDOW_DEPTH-1:0]    vld_r;
  logic [14:0]                mem_q_r;
  logic [14:0]                win_mem [WINDOW_DEPTH];
  logic [15:0]                base_r;
  logic [7:0]                 boost_r;
  logic                       chg_r, dis_r;

  // Output register.
  logic       out_valid_r;
  logic [6:0] out_level_r;
  logic       out_chg_r, out_dis_r;

  blce_pkg::div_req_t div_req;
  blce_pkg::div_rsp_t div_rsp;

  logic                       in_acc;
  logic                       out_free;
  logic                       mv_ge_full, mv_le_empty;
  logic [15:0]                mv_diff;
  logic [14:0]                old_sample;
  logic [6:0]                 quot_lvl;
  logic [17:0]                cur_bias, avg_bias;
  logic                       dis_now, direct_chg;
  logic                       base_zero, hard_drop, rise_hit, soft_drop, below_base;
  logic [7:0]                 boost_inc;
  logic [15:0]                base_nxt;
  logic [7:0]                 boost_nxt;
  logic                       chg_nxt;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_mv_r    <= 16'd3300;
      full_mv_r     <= 16'd4200;
      maint_mv_r    <= 16'd4150;
      dis_ma_r      <= 15'd5;
      rise_mv_r     <= 16'd25;
      reset_drop_r  <= 16'd80;
      drop_mv_r     <= 16'd10;
      streak_need_r <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EMPTY:      empty_mv_r    <= cfg_wdata;
        REG_FULL:       full_mv_r     <= cfg_wdata;
        REG_MAINT:      maint_mv_r    <= cfg_wdata;
        REG_DIS_MA:     dis_ma_r      <= cfg_wdata[14:0];
        REG_RISE:       rise_mv_r     <= cfg_wdata;
        REG_RESET_DROP: reset_drop_r  <= cfg_wdata;
        REG_DROP:       drop_mv_r     <= cfg_wdata;
        REG_STREAK:     streak_need_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- mapping
  assign mv_ge_full  = (s_mv_r >= full_mv_r);
  assign mv_le_empty = (s_mv_r <= empty_mv_r);
  assign mv_diff     = s_mv_r - empty_mv_r;

  // The divider is shared between the voltage mapping and the rounding of the
  // window average; the short run covers the rounding since the level is
  // always below 128.
  always_comb begin
    div_req.start     = (state_r == ST_LOAD1) || (state_r == ST_LOAD2);
    div_req.short_run = (state_r == ST_LOAD2);
    if (state_r == ST_LOAD2) begin
      div_req.num = blce_pkg::NUM_W'(sum_r + LVL_BIAS);
      div_req.den = LVL_DEN;
    end else begin
      div_req.num = prod_r;
      div_req.den = full_mv_r - empty_mv_r;
    end
  end

  blce_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign quot_lvl = div_rsp.quot[6:0];

  // ---------------------------------------------------------------- window
  // Entries not written since the window was primed still hold the first
  // sample, which is kept in a register rather than swept into the memory.
  assign old_sample = vld_r[idx_r] ? mem_q_r : first_r;

  always_ff @(posedge clk) begin
    mem_q_r <= win_mem[idx_r];
    if (state_r == ST_WIN && primed_r) begin
      win_mem[idx_r] <= raw_r;
    end
  end

  // ---------------------------------------------------------------- charge state
  // Adding the threshold to a current makes "below minus threshold" a sign test.
  assign cur_bias = {{2{s_cur_r[15]}}, s_cur_r} + {3'b000, dis_ma_r};
  assign avg_bias = {{2{s_avg_r[15]}}, s_avg_r} + {3'b000, dis_ma_r};
  assign dis_now  = cur_bias[17] || avg_bias[17];

  assign direct_chg = (!s_cur_r[15] && (s_cur_r != 16'd0))
                   || (!s_avg_r[15] && (s_avg_r != 16'd0))
                   || (s_ttf_r != blce_pkg::TTF_IDLE)
                   || (!s_flags_r[blce_pkg::FLAG_DSG_BIT] && s_flags_r[blce_pkg::FLAG_FC_BIT]
                       && (s_mv_r >= maint_mv_r))
                   || s_usb_r;

  assign base_zero  = (base_r == 16'd0);
  assign hard_drop  = ({1'b0, s_mv_r} + {1'b0, reset_drop_r}) < {1'b0, base_r};
  assign rise_hit   = {1'b0, s_mv_r} >= ({1'b0, base_r} + {1'b0, rise_mv_r});
  assign soft_drop  = ({1'b0, s_mv_r} + {1'b0, drop_mv_r}) < {1'b0, base_r};
  assign below_base = (s_mv_r < base_r);
  assign boost_inc  = (boost_r == 8'hFF) ? boost_r : boost_r + 8'd1;

  always_comb begin
    base_nxt  = base_r;
    boost_nxt = boost_r;
    chg_nxt   = 1'b0;
    if (dis_now) begin
      chg_nxt = 1'b0;
    end else if (direct_chg) begin
      chg_nxt = 1'b1;
    end else if (base_zero || hard_drop) begin
      base_nxt  = s_mv_r;
      boost_nxt = 8'd0;
    end else if (rise_hit) begin
      boost_nxt = boost_inc;
      chg_nxt   = (boost_inc >= streak_need_r);
    end else if (soft_drop) begin
      base_nxt  = s_mv_r;
      boost_nxt = 8'd0;
    end else if (below_base) begin
      base_nxt = s_mv_r;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_MAP;
      ST_MAP:   state_nxt = (mv_ge_full || mv_le_empty) ? ST_WIN : ST_LOAD1;
      ST_LOAD1: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = phase_r ? ST_DONE : ST_WIN;
        end
      end
      ST_WIN:   state_nxt = ST_LOAD2;
      ST_LOAD2: state_nxt = ST_DIV;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      primed_r    <= 1'b0;
      idx_r       <= '0;
      base_r      <= 16'd0;
      boost_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_WIN) begin
        base_r  <= base_nxt;
        boost_r <= boost_nxt;
        if (!primed_r) begin
          primed_r <= 1'b1;
          idx_r    <= '0;
        end else begin
          idx_r <= (idx_r == IDX_LAST) ? '0 : idx_r + IDX_W'(1);
        end
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_mv_r    <= in_tdata[15:0];
      s_cur_r   <= in_tdata[31:16];
      s_avg_r   <= in_tdata[47:32];
      s_flags_r <= in_tdata[63:48];
      s_ttf_r   <= in_tdata[79:64];
      s_usb_r   <= in_tdata[80];
    end
    if (state_r == ST_MAP) begin
      prod_r <= blce_pkg::NUM_W'(mv_diff) * blce_pkg::NUM_W'(blce_pkg::PCT_FULL_Q);
      if (mv_ge_full) begin
        raw_r <= blce_pkg::PCT_FULL_Q;
      end else if (mv_le_empty) begin
        raw_r <= 15'd0;
      end
    end
    if (state_r == ST_LOAD1) begin
      phase_r <= 1'b0;
    end
    if (state_r == ST_LOAD2) begin
      phase_r <= 1'b1;
    end
    if (state_r == ST_DIV && div_rsp.done) begin
      if (phase_r) begin
        level_r <= (quot_lvl > 7'd100) ? 7'd100 : quot_lvl;
      end else begin
        raw_r <= div_rsp.quot;
      end
    end
    if (state_r == ST_WIN) begin
      chg_r <= chg_nxt;
      dis_r <= dis_now;
      if (!primed_r) begin
        sum_r   <= SUM_W'(raw_r) * SUM_W'(WINDOW_DEPTH);
        first_r <= raw_r;
        vld_r   <= '0;
      end else begin
        sum_r        <= sum_r - SUM_W'(old_sample) + SUM_W'(raw_r);
        vld_r[idx_r] <= 1'b1;
      end
    end
    if (state_r == ST_DONE && out_free) begin
      out_level_r <= level_r;
      out_chg_r   <= chg_r;
      out_dis_r   <= dis_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_dis_r, out_chg_r, out_level_r};

  // ---------------------------------------------------------------- checks
`ifndef ASSERT_OFF
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[6:0] <= 7'd100))
    else $error("level above one hundred percent");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[7] && out_tdata[8]))
    else $error("charging and discharging both reported");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider finished outside its wait state");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    primed_r |-> (idx_r <= IDX_LAST))
    else $error("window index beyond window depth");
`endif

endmodule

// ===== hdl/blce_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blce_div: shared restoring divider
// Produces one quotient bit per cycle. A long run gives 15 quotient bits, a
// short run 7; the caller guarantees the quotient fits in that many bits.
// ----------------------------------------------------------------------------
module blce_div (
  input  logic                clk,
  input  logic                rst_n,
  input  blce_pkg::div_req_t  req,
  output blce_pkg::div_rsp_t  rsp
);

  logic [blce_pkg::DEN_W-1:0]  rem_r;
  logic [blce_pkg::QUOT_W-1:0] q_r;
  logic [blce_pkg::DEN_W-1:0]  den_r;
  logic [3:0]                  cnt_r;
  logic                        busy_r;
  logic                        done_r;

  logic [blce_pkg::DEN_W+1:0]  trial;
  logic                        fits;
  logic [blce_pkg::DEN_W-1:0]  rem_nxt;

  // The partial remainder stays below the divisor, so the shifted value fits
  // in one extra bit; the top bit of the difference is the borrow.
  assign trial   = {1'b0, rem_r, q_r[blce_pkg::QUOT_W-1]} - {2'b00, den_r};
  assign fits    = !trial[blce_pkg::DEN_W+1];
  assign rem_nxt = fits ? trial[blce_pkg::DEN_W-1:0]
                        : {rem_r[blce_pkg::DEN_W-2:0], q_r[blce_pkg::QUOT_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.short_run ? blce_pkg::DIV_STEPS_SHORT : blce_pkg::DIV_STEPS_LONG;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      den_r <= req.den;
      if (req.short_run) begin
        rem_r <= req.num[22:7];
        q_r   <= {req.num[6:0], 8'd0};
      end else begin
        rem_r <= req.num[30:15];
        q_r   <= req.num[14:0];
      end
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[blce_pkg::QUOT_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule
